[design/tbf_pkg.sv]
`timescale 1ns / 1ps
// tbf_pkg: shared types and constants of the ticketed bounded fifo
// no dependencies; used by the top level, its port checker and the testbench

package tbf_pkg;

    localparam int unsigned ID_W   = 48;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned CMD_W  = 2;

    // command codes carried in the slave-side tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // input tdata, last field in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]   ticket_in;
        logic [WORD_W-1:0] data_in;
    } t_in;

    // result tdata, last field in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]   oldest_id;
        logic [ID_W-1:0]   newest_id;
        logic              empty_res;
        logic              full_res;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] data_out;
        logic [ID_W-1:0]   ticket_out;
        logic              ok;
    } t_result;

    localparam int unsigned IN_W  = $bits(t_in);
    localparam int unsigned OUT_W = $bits(t_result);

endpackage

[design/tbf_ram.sv]
`timescale 1ns / 1ps
// tbf_ram: generic single-write, single-read ram with registered read data
// no dependencies

module tbf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/ticketed_bounded_fifo_unit.sv]
`timescale 1ns / 1ps
// ticketed_bounded_fifo_unit: bounded fifo whose entries carry 48-bit tickets
// depends on tbf_pkg and tbf_ram
//
//  channel  | dir | tdata (low bit up)                        | tuser
//  ---------+-----+-------------------------------------------+-------------
//  s_axis   | in  | data_in[31:0], ticket_in[79:32]           | cmd[1:0]
//  m_axis   | out | ok, ticket_out, data_out, count, full_res,| none
//           |     | empty_res, newest_id, oldest_id (184 bits) |
//
//  one command per cycle; its result appears in the cycle after the transfer
//  the result comes from the single result register and the registered ram read
//  a new command is taken while the held result is being taken downstream
//  a stalled result blocks the slave side only while it cannot move on
//  synchronous active-low reset empties the queue; slot contents are kept

module ticketed_bounded_fifo_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // data_in[31:0], ticket_in[79:32]
    input  logic [tbf_pkg::IN_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [tbf_pkg::CMD_W-1:0] s_axis_tuser,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // ok[0], ticket_out[48:1], data_out[80:49], count[85:81], full_res[86],
    // empty_res[87], newest_id[135:88], oldest_id[183:136]
    output logic [tbf_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready
);

    import tbf_pkg::*;

    // slot index and occupancy widths
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = ((AW > CW) ? AW : CW) + 1;

    // queue state
    logic [ID_W-1:0] r_head_id, n_head_id;
    logic [ID_W-1:0] r_tail_id, n_tail_id;
    logic [AW-1:0]   r_head_slot, n_head_slot;
    logic [AW-1:0]   r_tail_slot, n_tail_slot;
    logic [CW-1:0]   r_count, n_count;

    // result register
    logic              r_out_valid;
    logic              r_ok, n_ok;
    logic              r_rd_ok, n_rd_ok;
    logic [ID_W-1:0]   r_ticket_out, n_ticket_out;
    logic [CNT_W-1:0]  r_count_res;
    logic              r_full_res, r_empty_res;
    logic [ID_W-1:0]   r_newest_id, r_oldest_id;

    // incoming transfer
    logic      accept;
    t_in       in_w;
    t_cmd      cmd;
    logic [ID_W-1:0] offset;
    logic      held;
    logic      full;
    logic [SW-1:0]   slot_sum;
    logic [AW-1:0]   rd_slot;
    logic      wr_en, rd_en;
    logic [WORD_W-1:0] ram_q;
    t_result   res;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_w          = t_in'(s_axis_tdata);
    assign cmd           = t_cmd'(s_axis_tuser);

    // a ticket is held when its distance from the tail is below the count
    assign offset = in_w.ticket_in - r_tail_id;
    assign held   = offset < ID_W'(r_count);
    assign full   = r_count == CW'(DEPTH);

    // slot of a held ticket: tail slot plus distance, wrapped once
    assign slot_sum = SW'(r_tail_slot) + SW'(offset[CW-1:0]);
    assign rd_slot  = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH))
                                               : AW'(slot_sum);

    always_comb begin
        n_head_id    = r_head_id;
        n_tail_id    = r_tail_id;
        n_head_slot  = r_head_slot;
        n_tail_slot  = r_tail_slot;
        n_count      = r_count;
        n_ok         = 1'b0;
        n_rd_ok      = 1'b0;
        n_ticket_out = '0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (cmd)
            CMD_ENQ: begin
                if (!full) begin
                    wr_en        = accept;
                    n_ok         = 1'b1;
                    n_ticket_out = r_head_id;
                    n_head_id    = r_head_id + ID_W'(1);
                    n_head_slot  = (r_head_slot == AW'(DEPTH - 1)) ? '0
                                                                  : r_head_slot + AW'(1);
                    n_count      = r_count + CW'(1);
                end
            end
            CMD_DEQ: begin
                if (in_w.ticket_in == r_tail_id && r_count != '0) begin
                    n_ok        = 1'b1;
                    n_tail_id   = r_tail_id + ID_W'(1);
                    n_tail_slot = (r_tail_slot == AW'(DEPTH - 1)) ? '0
                                                                 : r_tail_slot + AW'(1);
                    n_count     = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (held) begin
                    rd_en   = accept;
                    n_ok    = 1'b1;
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
                // unused code: status only
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_id   <= '0;
            r_tail_id   <= '0;
            r_head_slot <= '0;
            r_tail_slot <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head_id   <= n_head_id;
                r_tail_id   <= n_tail_id;
                r_head_slot <= n_head_slot;
                r_tail_slot <= n_tail_slot;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok         <= n_ok;
            r_rd_ok      <= n_rd_ok;
            r_ticket_out <= n_ticket_out;
            r_count_res  <= CNT_W'(n_count);
            r_full_res   <= n_count == CW'(DEPTH);
            r_empty_res  <= n_count == '0;
            r_newest_id  <= (n_count != '0) ? n_head_id - ID_W'(1) : '0;
            r_oldest_id  <= (n_count != '0) ? n_tail_id : '0;
        end
    end

    // slot storage; read data lines up with the result register
    tbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_head_slot),
        .i_wr_data (in_w.data_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_slot),
        .o_rd_data (ram_q)
    );

    always_comb begin
        res.ok         = r_ok;
        res.ticket_out = r_ticket_out;
        res.data_out   = r_rd_ok ? ram_q : '0;
        res.count      = r_count_res;
        res.full_res   = r_full_res;
        res.empty_res  = r_empty_res;
        res.newest_id  = r_newest_id;
        res.oldest_id  = r_oldest_id;
    end

    assign m_axis_tdata  = res;
    assign m_axis_tvalid = r_out_valid;

endmodule

[design/tbf_checker.sv]
`timescale 1ns / 1ps
// tbf_port_checker: port-level checks of ticketed_bounded_fifo_unit, bound in below
// depends on tbf_pkg

module tbf_port_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic [tbf_pkg::IN_W-1:0]  s_axis_tdata,
    input logic [tbf_pkg::CMD_W-1:0] s_axis_tuser,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [tbf_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready
);

    import tbf_pkg::*;

    t_result res;
    assign res = t_result'(m_axis_tdata);

    // a held result is not dropped while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // a stalled result blocks new commands
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("command taken while result stalled");

    // every transfer in produces a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after transfer");

    // an empty queue reports zero ids and a zero count; nonzero data only with ok set
    a_empty_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.empty_res |->
            res.newest_id == '0 && res.oldest_id == '0 && res.count == '0)
        else $error("empty result carries ids");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.data_out != '0 |-> res.ok)
        else $error("data returned by a failed command");

endmodule

bind ticketed_bounded_fifo_unit tbf_port_checker u_tbf_port_checker (.*);

[sim/tbf_checker.sv]
`timescale 1ns / 1ps
// tbf_checker: watches both stream channels of the ticketed bounded fifo,
// predicts every result and compares it field by field; depends on tbf_pkg

module tbf_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // data_in, ticket_in
    input  logic [tbf_pkg::IN_W-1:0]  i_s_tdata,
    // cmd
    input  logic [tbf_pkg::CMD_W-1:0] i_s_tuser,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    // ok, ticket_out, data_out, count, full_res, empty_res, newest_id, oldest_id
    input  logic [tbf_pkg::OUT_W-1:0] i_m_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    output int                        o_mismatches,
    output int                        o_pending
);
    import tbf_pkg::*;

    logic [WORD_W-1:0] shadow_slots [DEPTH];
    logic [ID_W-1:0]   shadow_head;
    logic [ID_W-1:0]   shadow_tail;
    t_result           awaited_q [$];
    int                mismatch_total = 0;

    // applies one command to the shadow queue and returns its result
    function automatic t_result fifo_outcome(input logic [CMD_W-1:0] cmd, input t_in item);
        t_result         res;
        logic [ID_W-1:0] held;
        res  = '0;
        held = shadow_head - shadow_tail;
        case (cmd)
            CMD_ENQ: begin
                if (held < DEPTH) begin
                    shadow_slots[shadow_head % DEPTH] = item.data_in;
                    res.ticket_out = shadow_head;
                    shadow_head    = shadow_head + 1'b1;
                    res.ok         = 1'b1;
                end
            end
            CMD_DEQ: begin
                if (item.ticket_in == shadow_tail && held != '0) begin
                    shadow_tail = shadow_tail + 1'b1;
                    res.ok      = 1'b1;
                end
            end
            CMD_READ: begin
                // held means within the window starting at the oldest ticket
                if (ID_W'(item.ticket_in - shadow_tail) < held) begin
                    res.data_out = shadow_slots[item.ticket_in % DEPTH];
                    res.ok       = 1'b1;
                end
            end
            default: ;
        endcase
        held          = shadow_head - shadow_tail;
        res.count     = held[CNT_W-1:0];
        res.full_res  = (held == DEPTH);
        res.empty_res = (held == '0);
        if (held != '0) begin
            res.newest_id = shadow_head - 1'b1;
            res.oldest_id = shadow_tail;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            mismatch_total++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shadow_head = '0;
            shadow_tail = '0;
            awaited_q.delete();
        end else begin
            // result side first: it belongs to an older command
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (awaited_q.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result transfer with none expected, got 0x%0h",
                             $time, i_m_tdata);
                end else begin
                    want = awaited_q.pop_front();
                    check_field("ok", 64'(want.ok), 64'(got.ok));
                    check_field("ticket_out", 64'(want.ticket_out), 64'(got.ticket_out));
                    check_field("data_out", 64'(want.data_out), 64'(got.data_out));
                    check_field("count", 64'(want.count), 64'(got.count));
                    check_field("full_res", 64'(want.full_res), 64'(got.full_res));
                    check_field("empty_res", 64'(want.empty_res), 64'(got.empty_res));
                    check_field("newest_id", 64'(want.newest_id), 64'(got.newest_id));
                    check_field("oldest_id", 64'(want.oldest_id), 64'(got.oldest_id));
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_q.push_back(fifo_outcome(i_s_tuser, t_in'(i_s_tdata)));
        end
        o_pending    <= awaited_q.size();
        o_mismatches <= mismatch_total;
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for ticketed_bounded_fifo_unit
// depends on tbf_pkg, the design and tbf_checker, which does the predicting

module tb_top;
    import tbf_pkg::*;

    localparam int unsigned DEPTH = 16;
    // tuser code the block leaves unused, must be a no-op
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    // cycles with no transfer on either side before the run is abandoned
    localparam int STALL_LIMIT = 1000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;    // data_in, ticket_in
    logic [CMD_W-1:0]  s_tuser = '0;    // cmd
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;         // ok .. oldest_id, see tbf_pkg
    logic              m_tvalid;
    logic              m_tready = 1'b0;

    int                mismatches;
    int                pending;
    int                quiet_cycles = 0;

    // stretch flag shared by both sides: no idling while it is set
    logic              calm = 1'b0;

    // stimulus-side view of the ticket window, used only to aim tickets
    logic [ID_W-1:0]   next_ticket = '0;
    logic [ID_W-1:0]   oldest_ticket = '0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ticketed_bounded_fifo_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready)
    );

    tbf_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // any 48-bit ticket, so every ticket bit gets both values
    function automatic logic [ID_W-1:0] any_ticket();
        return ID_W'({$urandom(), $urandom()});
    endfunction

    // one transfer on the slave side, preceded by a random gap
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                         input logic [ID_W-1:0] ticket);
        int   gap;
        t_in  item;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.data_in   = word;
        item.ticket_in = ticket;
        s_tdata  <= item;
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        // keep the aiming window in step with what the block just took
        case (cmd)
            CMD_ENQ: begin
                if (ID_W'(next_ticket - oldest_ticket) < DEPTH)
                    next_ticket = next_ticket + 1'b1;
            end
            CMD_DEQ: begin
                if (ticket == oldest_ticket && next_ticket != oldest_ticket)
                    oldest_ticket = oldest_ticket + 1'b1;
            end
            default: ;
        endcase
    endtask

    // hold the sender off until every outstanding result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // receiver: a random stall ahead of every result transfer
    initial begin
        int stall;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int              enq_pct;
        int              roll;
        int              sel;
        int              held;
        logic [ID_W-1:0] aim;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, unused code, word extremes, full queue
        issue(CMD_READ, '1, '0);            // read while empty
        issue(CMD_DEQ, '0, '0);             // dequeue while empty
        issue(CMD_NOP, '1, '1);             // unused code, all ones elsewhere
        issue(CMD_ENQ, '0, '1);             // word of zeros
        issue(CMD_ENQ, '1, '0);             // word of ones
        issue(CMD_READ, $urandom(), 48'd1);
        issue(CMD_READ, '0, 48'd0);
        issue(CMD_READ, '0, 48'd2);         // next ticket, not yet held
        for (int k = 0; k < 14; k++)
            issue(CMD_ENQ, $urandom(), any_ticket());
        issue(CMD_ENQ, '1, '0);             // refused, queue full
        issue(CMD_DEQ, '0, 48'd1);          // not the oldest ticket
        issue(CMD_DEQ, '0, 48'd0);
        issue(CMD_READ, '0, '1);            // largest ticket, not held
        drain();

        // random: blocks leaning towards filling, balance or emptying
        for (int blk = 0; blk < 16; blk++) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 15;
                1: enq_pct = 40;
                default: enq_pct = 70;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 50; n++) begin
                roll = $urandom_range(0, 99);
                sel  = $urandom_range(0, 9);
                held = int'(ID_W'(next_ticket - oldest_ticket));
                if (roll < enq_pct) begin
                    issue(CMD_ENQ, $urandom(), any_ticket());
                end else if (roll < enq_pct + (100 - enq_pct) / 2) begin
                    // mostly the right ticket, now and then a near miss or noise
                    if (sel < 8)
                        aim = oldest_ticket;
                    else if (sel == 8)
                        aim = ($urandom_range(0, 1) == 0) ? oldest_ticket + 1'b1
                                                          : oldest_ticket - 1'b1;
                    else
                        aim = any_ticket();
                    issue(CMD_DEQ, $urandom(), aim);
                end else if (roll < 95) begin
                    // mostly a held ticket, else just outside the window or noise
                    if (sel < 8 && held != 0)
                        aim = oldest_ticket + ID_W'($urandom_range(0, held - 1));
                    else if (sel == 8)
                        aim = ($urandom_range(0, 1) == 0) ? next_ticket
                                                          : oldest_ticket - 1'b1;
                    else
                        aim = any_ticket();
                    issue(CMD_READ, $urandom(), aim);
                end else begin
                    issue(CMD_NOP, $urandom(), any_ticket());
                end
            end
            if (blk % 5 == 2)
                drain();
        end
        calm = 1'b0;

        // let the last results out, then a short settle for stray transfers
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
